// ===== src/rls_pkg.sv =====
package rls_pkg;

  localparam int SIGNAL_FRAC_BITS = 16;
  localparam int COV_FRAC_BITS = 30;

  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_INIT_A = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INIT_B = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_INIT_COV = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE = 2'd3;

  localparam logic signed [31:0] INIT_A_RESET = 32'sd3277;
  localparam logic signed [31:0] INIT_B_RESET = 32'sd655;
  localparam logic [30:0] INIT_COV_RESET = 31'd1717987;
  localparam logic [30:0] SCALE_RESET = 31'd1072668082;

  // operation of the shared multiply-accumulate unit
  typedef enum logic [1:0] {
    MAC_LOAD = 2'd0,  // acc = product >>> shift
    MAC_ADD  = 2'd1,  // acc += product >>> shift
    MAC_SUBC = 2'd2,  // acc = c - (product >>> shift)
    MAC_ADDC = 2'd3   // acc = c + (product >>> shift)
  } mac_op_t;

  typedef struct packed {
    logic              en;
    mac_op_t           op;
    logic              sh_cov;  // shift by COV_FRAC_BITS, else SIGNAL_FRAC_BITS
    logic signed [31:0] a;
    logic signed [31:0] b;
    logic signed [32:0] c;
  } mac_cmd_t;

  function automatic logic signed [31:0] sat32(input logic signed [65:0] x);
    logic signed [65:0] hi;
    logic signed [65:0] lo;
    hi = 66'sd2147483647;
    lo = -66'sd2147483648;
    if (x > hi) return 32'sh7fffffff;
    if (x < lo) return 32'sh80000000;
    return x[31:0];
  endfunction

endpackage

// ===== src/rls_mac.sv =====
module rls_mac #(
  parameter int SFB = rls_pkg::SIGNAL_FRAC_BITS,
  parameter int CFB = rls_pkg::COV_FRAC_BITS
) (
  input  logic                clk,
  input  rls_pkg::mac_cmd_t   cmd,
  output logic signed [65:0]  acc
);

  logic signed [63:0] prod;
  logic signed [63:0] shv;

  always_comb begin
    prod = 64'(cmd.a) * 64'(cmd.b);
    shv = cmd.sh_cov ? (prod >>> CFB) : (prod >>> SFB);
  end

  always_ff @(posedge clk) begin
    if (cmd.en) begin
      case (cmd.op)
        rls_pkg::MAC_LOAD: acc <= 66'(shv);
        rls_pkg::MAC_ADD:  acc <= acc + 66'(shv);
        rls_pkg::MAC_SUBC: acc <= 66'(cmd.c) - 66'(shv);
        rls_pkg::MAC_ADDC: acc <= 66'(cmd.c) + 66'(shv);
        default:           acc <= acc;
      endcase
    end
  end

endmodule

// ===== src/rls_div.sv =====
module rls_div #(
  parameter int CFB = rls_pkg::COV_FRAC_BITS
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic signed [31:0] num,
  input  logic [63:0]        den,
  output logic               busy,
  output logic signed [31:0] quo
);

  // restoring division of |num| << CFB by den, one bit a cycle
  localparam int NW = 32 + CFB;
  localparam int CW = $clog2(NW + 1);

  logic [NW-1:0] dvd;
  logic [64:0]   rem;
  logic [NW-1:0] q;
  logic [CW-1:0] cnt;
  logic          neg;
  logic [64:0]   trial;
  logic signed [NW:0] sq;
  logic [31:0]   mag;

  always_comb begin
    mag = num[31] ? (~num + 32'd1) : num;
    trial = {rem[63:0], dvd[NW-1]} - {1'b0, den};
    sq = neg ? -$signed({1'b0, q}) : $signed({1'b0, q});
    quo = rls_pkg::sat32(66'(sq));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
      cnt <= CW'(NW);
      neg <= num[31];
      dvd <= {mag, {CFB{1'b0}}};
      rem <= '0;
      q <= '0;
    end else if (busy) begin
      dvd <= dvd << 1;
      if (!trial[64]) begin
        rem <= trial;
        q <= {q[NW-2:0], 1'b1};
      end else begin
        rem <= {rem[63:0], dvd[NW-1]};
        q <= {q[NW-2:0], 1'b0};
      end
      cnt <= cnt - 1'b1;
      if (cnt == CW'(1)) busy <= 1'b0;
    end
  end

endmodule

// ===== src/rls_two_parameter_estimator.sv =====
// Channel | Dir | Fields
// s_axis  | in  | tdata: regressor_a, regressor_b, measured_voltage; tuser: restart
// m_axis  | out | tdata: estimate_a, estimate_b
// cfg     | in  | cfg_index (register number), cfg_data
//
// Each item runs through the MAC steps, two bit-serial divisions (one per gain) and
// the update steps before the next accept. With a non-positive denominator the
// divisions and the update are dropped.
// The output word is registered at accept; the next item is held off until
// that word has left on m_axis. Reset (rst) loads default registers and state.
module rls_two_parameter_estimator #(
  parameter int SIGNAL_FRAC_BITS = rls_pkg::SIGNAL_FRAC_BITS,
  parameter int COV_FRAC_BITS = rls_pkg::COV_FRAC_BITS
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [95:0] s_axis_tdata,   // regressor_a, regressor_b, measured_voltage
  input  logic        s_axis_tuser,   // restart
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata,   // estimate_a, estimate_b
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  // defaults: 0.05, 0.01, 0.0016 and 0.999 at the chosen fraction widths
  localparam logic signed [31:0] INIT_A_DEF =
    32'(((64'd5 << SIGNAL_FRAC_BITS) + 64'd50) / 64'd100);
  localparam logic signed [31:0] INIT_B_DEF =
    32'(((64'd1 << SIGNAL_FRAC_BITS) + 64'd50) / 64'd100);
  localparam logic [30:0] INIT_COV_DEF =
    31'(((64'd16 << COV_FRAC_BITS) + 64'd5000) / 64'd10000);
  localparam logic [30:0] SCALE_DEF =
    31'(((64'd999 << COV_FRAC_BITS) + 64'd500) / 64'd1000);

  typedef enum logic [2:0] {
    S_IDLE, S_MAC, S_DIVA, S_DIVB, S_UPD
  } state_t;

  state_t state;
  logic [4:0] step;

  logic signed [31:0] init_a, init_b;
  logic [30:0] init_cov, scale;
  logic signed [31:0] th_a, th_b, p_aa, p_ab, p_ba, p_bb;
  logic signed [31:0] ha, hb, uq;
  logic signed [31:0] ga, gb, ra, rb, s, e, ka, kb;
  logic signed [65:0] d;

  rls_pkg::mac_cmd_t cmd;
  logic signed [65:0] acc;
  logic div_start, div_busy, div_start_q;
  logic signed [31:0] div_num, div_q;

  rls_mac #(.SFB(SIGNAL_FRAC_BITS), .CFB(COV_FRAC_BITS)) u_mac (
    .clk(clk), .cmd(cmd), .acc(acc)
  );

  rls_div #(.CFB(COV_FRAC_BITS)) u_div (
    .clk(clk), .rst(rst), .start(div_start), .num(div_num),
    .den(d[63:0]), .busy(div_busy), .quo(div_q)
  );

  assign cfg_ready = 1'b1;
  assign s_axis_tready = (state == S_IDLE) && !m_axis_tvalid;
  assign div_num = (state == S_MAC) ? ga : gb;

  // MAC schedule: each step issues a command; the accumulated result is captured on the following step
  always_comb begin
    cmd = '0;
    cmd.en = (state == S_MAC) || (state == S_UPD);
    if (state == S_MAC) begin
      case (step)
        5'd0: begin cmd.op = rls_pkg::MAC_LOAD; cmd.sh_cov = 1'b1; cmd.a = p_aa; cmd.b = ha; end
        5'd1: begin cmd.op = rls_pkg::MAC_ADD;  cmd.sh_cov = 1'b1; cmd.a = p_ab; cmd.b = hb; end
        5'd2: begin cmd.op = rls_pkg::MAC_LOAD; cmd.sh_cov = 1'b1; cmd.a = p_ba; cmd.b = ha; end
        5'd3: begin cmd.op = rls_pkg::MAC_ADD;  cmd.sh_cov = 1'b1; cmd.a = p_bb; cmd.b = hb; end
        5'd4: begin cmd.op = rls_pkg::MAC_LOAD; cmd.sh_cov = 1'b1; cmd.a = ha; cmd.b = p_aa; end
        5'd5: begin cmd.op = rls_pkg::MAC_ADD;  cmd.sh_cov = 1'b1; cmd.a = hb; cmd.b = p_ba; end
        5'd6: begin cmd.op = rls_pkg::MAC_LOAD; cmd.sh_cov = 1'b1; cmd.a = ha; cmd.b = p_ab; end
        5'd7: begin cmd.op = rls_pkg::MAC_ADD;  cmd.sh_cov = 1'b1; cmd.a = hb; cmd.b = p_bb; end
        5'd8: begin cmd.op = rls_pkg::MAC_LOAD; cmd.a = ha; cmd.b = th_a; end
        5'd9: begin cmd.op = rls_pkg::MAC_ADD;  cmd.a = hb; cmd.b = th_b; end
        5'd10: begin cmd.op = rls_pkg::MAC_LOAD; cmd.a = ra; cmd.b = ha; end
        5'd11: begin cmd.op = rls_pkg::MAC_ADD;  cmd.a = rb; cmd.b = hb; end
        5'd12: begin
          cmd.op = rls_pkg::MAC_SUBC; cmd.sh_cov = 1'b1; cmd.a = s;
          cmd.b = $signed({1'b0, scale}); cmd.c = 33'(uq);
        end
        default: cmd.en = 1'b0;
      endcase
    end else if (state == S_UPD) begin
      case (step)
        5'd0: begin cmd.op = rls_pkg::MAC_SUBC; cmd.a = ka; cmd.b = ra; cmd.c = 33'(p_aa); end
        5'd1: begin cmd.op = rls_pkg::MAC_SUBC; cmd.a = ka; cmd.b = rb; cmd.c = 33'(p_ab); end
        5'd2: begin cmd.op = rls_pkg::MAC_SUBC; cmd.a = kb; cmd.b = ra; cmd.c = 33'(p_ba); end
        5'd3: begin cmd.op = rls_pkg::MAC_SUBC; cmd.a = kb; cmd.b = rb; cmd.c = 33'(p_bb); end
        // theta + k*e, product floored
        5'd4: begin
          cmd.op = rls_pkg::MAC_ADDC; cmd.sh_cov = 1'b1; cmd.a = ka; cmd.b = e;
          cmd.c = 33'(th_a);
        end
        5'd5: begin
          cmd.op = rls_pkg::MAC_ADDC; cmd.sh_cov = 1'b1; cmd.a = kb; cmd.b = e;
          cmd.c = 33'(th_b);
        end
        default: cmd.en = 1'b0;
      endcase
    end
  end

  // first division starts as the MAC phase ends, the second once the first is done
  assign div_start = ((state == S_MAC) && (step == 5'd14) && (d > 66'sd0)) ||
                     ((state == S_DIVA) && !div_busy && !div_start_q);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      step <= '0;
      m_axis_tvalid <= 1'b0;
      div_start_q <= 1'b0;
      init_a <= INIT_A_DEF;
      init_b <= INIT_B_DEF;
      init_cov <= INIT_COV_DEF;
      scale <= SCALE_DEF;
      th_a <= INIT_A_DEF;
      th_b <= INIT_B_DEF;
      p_aa <= $signed({1'b0, INIT_COV_DEF});
      p_ab <= '0;
      p_ba <= '0;
      p_bb <= $signed({1'b0, INIT_COV_DEF});
    end else begin
      div_start_q <= div_start;
      if (m_axis_tvalid && m_axis_tready) m_axis_tvalid <= 1'b0;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          rls_pkg::REG_INIT_A:   init_a <= cfg_data;
          rls_pkg::REG_INIT_B:   init_b <= cfg_data;
          rls_pkg::REG_INIT_COV: init_cov <= cfg_data[30:0];
          rls_pkg::REG_SCALE:    scale <= cfg_data[30:0];
          default: ;
        endcase
      end
      case (state)
        S_IDLE: begin
          if (s_axis_tvalid && s_axis_tready) begin
            ha <= s_axis_tdata[31:0];
            hb <= s_axis_tdata[63:32];
            uq <= s_axis_tdata[95:64];
            if (s_axis_tuser) begin
              th_a <= init_a;
              th_b <= init_b;
              p_aa <= $signed({1'b0, init_cov});
              p_ab <= '0;
              p_ba <= '0;
              p_bb <= $signed({1'b0, init_cov});
              m_axis_tdata <= {init_b, init_a};
            end else begin
              m_axis_tdata <= {th_b, th_a};
            end
            m_axis_tvalid <= 1'b1;
            step <= '0;
            state <= S_MAC;
          end
        end
        S_MAC: begin
          step <= step + 1'b1;
          case (step)
            5'd2:  ga <= rls_pkg::sat32(acc);
            5'd4:  gb <= rls_pkg::sat32(acc);
            5'd6:  ra <= rls_pkg::sat32(acc);
            5'd8:  rb <= rls_pkg::sat32(acc);
            5'd10: s <= rls_pkg::sat32(acc);
            5'd12: d <= acc + (66'sd1 <<< SIGNAL_FRAC_BITS);
            5'd13: e <= rls_pkg::sat32(acc);
            5'd14: state <= (d > 66'sd0) ? S_DIVA : S_IDLE;
            default: ;
          endcase
        end
        S_DIVA: begin
          // take the first gain; the second division starts on this edge
          if (!div_busy && !div_start_q) begin
            ka <= div_q;
            state <= S_DIVB;
          end
        end
        S_DIVB: begin
          if (!div_busy && !div_start_q) begin
            kb <= div_q;
            step <= '0;
            state <= S_UPD;
          end
        end
        S_UPD: begin
          step <= step + 1'b1;
          case (step)
            5'd1: p_aa <= rls_pkg::sat32(acc);
            5'd2: p_ab <= rls_pkg::sat32(acc);
            5'd3: p_ba <= rls_pkg::sat32(acc);
            5'd4: p_bb <= rls_pkg::sat32(acc);
            5'd5: th_a <= rls_pkg::sat32(acc);
            5'd6: begin
              th_b <= rls_pkg::sat32(acc);
              state <= S_IDLE;
            end
            default: ;
          endcase
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> !s_axis_tready) else $error("accept while busy");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid) else $error("output dropped");
  a_div_idle: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> !div_busy) else $error("divider busy in idle");
`endif

endmodule
